// ----- rtl/mfd_pkg.sv -----
`default_nettype none

package mfd_pkg;

   // slot map: small motors 0..3, mid motors 4..7, large motors 8..10
   localparam int NUM_SLOTS = 11;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int SUB_W     = 2;

   localparam int ID_W      = 11;
   localparam int BYTE_W    = 8;
   localparam int NUM_BYTES = 7;
   localparam int ENC_W     = 16;
   localparam int TURN_W    = 19;
   localparam int TOTAL_W   = 32;
   localparam int GEAR_FRAC = 8;
   localparam int GEAR_W    = 40;

   // stream widths, rounded up to whole bytes
   localparam int REQ_BITS   = ID_W + NUM_BYTES * BYTE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W;
   localparam int RSP_BITS   = SUB_W + 1 + 3 * ENC_W + BYTE_W + TURN_W + TOTAL_W + GEAR_W;
   localparam int RSP_DATA_W = ((RSP_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W;
   localparam int GRP_W      = 2;

   // register indexes
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_SMALL_BASE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MID_BASE   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LARGE_BASE = 2'd2;

   localparam logic [ID_W-1:0] SMALL_BASE_RST = 11'd513;
   localparam logic [ID_W-1:0] MID_BASE_RST   = 11'd517;
   localparam logic [ID_W-1:0] LARGE_BASE_RST = 11'd521;

   localparam int SMALL_COUNT = 4;
   localparam int MID_PER_BUS = 2;
   localparam int LARGE_COUNT = 3;
   localparam logic [SLOT_W-1:0] MID_SLOT0   = 4'd4;
   localparam logic [SLOT_W-1:0] LARGE_SLOT0 = 4'd8;

   // unwrap constants
   localparam logic signed [ENC_W:0]    ENC_HALF     = 17'sd4096;
   localparam logic signed [ENC_W:0]    ENC_HALF_NEG = -17'sd4096;
   localparam int                       ENC_SHIFT    = 13;
   localparam logic signed [TURN_W-1:0] TURN_MAX     = {1'b0, {(TURN_W-1){1'b1}}};
   localparam logic signed [TURN_W-1:0] TURN_MIN     = {1'b1, {(TURN_W-1){1'b0}}};

   // gear scaling: geared = total * NUM / DIV, reciprocal = floor(2^32 / DIV)
   localparam int DIV_W   = 12;
   localparam int NUM_W   = 16;
   localparam int RECIP_W = 32;
   localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_W;
   localparam logic [DIV_W-1:0]   DIV_SMALL   = 12'd36;
   localparam logic [DIV_W-1:0]   DIV_MID     = 12'd3591;
   localparam logic [DIV_W-1:0]   DIV_LARGE   = 12'd1;
   localparam logic [NUM_W-1:0]   NUM_SMALL   = 16'd256;
   localparam logic [NUM_W-1:0]   NUM_MID     = 16'd47872;
   localparam logic [NUM_W-1:0]   NUM_LARGE   = 16'd256;
   localparam logic [RECIP_W-1:0] RECIP_SMALL = RECIP_W'(RECIP_ONE / DIV_SMALL);
   localparam logic [RECIP_W-1:0] RECIP_MID   = RECIP_W'(RECIP_ONE / DIV_MID);
   // divide by one: 2^32 - 1 leaves the estimate at most one low, fixed by the correction
   localparam logic [RECIP_W-1:0] RECIP_LARGE = {RECIP_W{1'b1}};

   typedef enum logic [GRP_W-1:0] {
      GRP_SMALL = 2'd0,
      GRP_MID   = 2'd1,
      GRP_LARGE = 2'd2
   } group_type;

   // classified frame waiting in the queue
   typedef struct packed {
      group_type         grp;
      logic [SUB_W-1:0]  sub;
      logic [SLOT_W-1:0] slot;
      logic [ENC_W-1:0]  enc;
      logic [ENC_W-1:0]  speed;
      logic [ENC_W-1:0]  current;
      logic [BYTE_W-1:0] temp;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // result record carried down the back end
   typedef struct packed {
      group_type          grp;
      logic [SUB_W-1:0]   sub;
      logic               first;
      logic [ENC_W-1:0]   enc;
      logic [ENC_W-1:0]   speed;
      logic [ENC_W-1:0]   current;
      logic [BYTE_W-1:0]  temp;
      logic [TURN_W-1:0]  turns;
      logic [TOTAL_W-1:0] total;
   } rec_type;

endpackage

`default_nettype wire

// ----- rtl/motor_feedback_multiturn_decoder_core.sv -----
`default_nettype none

// Motor feedback decoder with multiturn unwrap. Each beat on req_ is one received CAN
// frame; frames whose ID matches one of the eleven motor slots (four small and two mid
// motors on bus 0, two mid and three large motors on bus 1) give one beat on rsp_,
// others are taken and dropped. A slot's first frame sets its zero offset; after that
// jumps above half a turn move the saturating turn count. The block takes one frame per
// clock while its queue has room: a four-entry queue decouples classification from the
// back end, which updates slot state as each frame leaves the queue and then runs a
// nine-stage fixed-point scaling pipeline. A stalled result freezes the back end;
// req_tready drops only once the queue has filled behind it. Base IDs are written on
// csr_ and should change only while idle.
module motor_feedback_multiturn_decoder_core import mfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_addr,
   input  logic [ID_W-1:0]       csr_wdata,
   // received frames
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // std_id, data_byte_0 .. data_byte_6, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // bus_select
   input  logic                  req_tuser,
   // decoded feedback
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor_slot, first_frame, encoder_value, rotor_speed, drive_current, temperature,
   // turn_count, total_position, geared_position, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // motor_group
   output logic [GRP_W-1:0]      rsp_tuser
);

   logic              adv;
   head_type          head;
   logic              rec_valid;
   rec_type           rec;
   rec_type           out_rec;
   logic [GEAR_W-1:0] out_geared;

   // back end moves whenever the output register is free or being drained
   assign adv = !rsp_tvalid || rsp_tready;

   mfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (adv),
      .head       (head)
   );

   mfd_unwrap u_unwrap (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .head      (head),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   mfd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (rec_valid),
      .in_rec     (rec),
      .out_valid  (rsp_tvalid),
      .out_rec    (out_rec),
      .out_geared (out_geared)
   );

   // result packing
   assign rsp_tuser = out_rec.grp;
   assign rsp_tdata = {{(RSP_DATA_W-RSP_BITS){1'b0}},
                       out_geared,
                       out_rec.total,
                       out_rec.turns,
                       out_rec.temp,
                       out_rec.current,
                       out_rec.speed,
                       out_rec.enc,
                       out_rec.first,
                       out_rec.sub};

   // a first frame sits exactly on its zero offset
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_rec.first |->
         out_rec.turns == '0 && out_rec.total == '0 && out_geared == '0)
      else $error("first frame result not at zero");

   // large group is the total with eight fraction bits
   a_large_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_rec.grp == GRP_LARGE |->
         out_geared == {out_rec.total, {GEAR_FRAC{1'b0}}})
      else $error("large group geared position mismatch");

   // scaling never flips the sign of the position
   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_geared[GEAR_W-1] == out_rec.total[TOTAL_W-1])
      else $error("geared position sign differs from total");

endmodule

`default_nettype wire

// ----- rtl/mfd_front.sv -----
`default_nettype none

module mfd_front import mfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_addr,
   input  logic [ID_W-1:0]       csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  pop,
   output head_type              head
);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   logic [ID_W-1:0]   small_base_ff;
   logic [ID_W-1:0]   mid_base_ff;
   logic [ID_W-1:0]   large_base_ff;
   logic [ID_W-1:0]   id;
   logic [ID_W:0]     small_diff;
   logic [ID_W:0]     mid_diff;
   logic [ID_W:0]     large_diff;
   logic              small_hit;
   logic              mid0_hit;
   logic              mid1_hit;
   logic              large_hit;
   logic              hit;
   item_type          item_in;
   item_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              take;

   // base id registers
   always_ff @(posedge clock) begin
      if (reset) begin
         small_base_ff <= SMALL_BASE_RST;
         mid_base_ff   <= MID_BASE_RST;
         large_base_ff <= LARGE_BASE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SMALL_BASE: small_base_ff <= csr_wdata;
            REG_MID_BASE:   mid_base_ff   <= csr_wdata;
            REG_LARGE_BASE: large_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // id match: offset from each base, borrow bit set when id is below base
   always_comb begin
      id         = req_tdata[ID_W-1:0];
      small_diff = {1'b0, id} - {1'b0, small_base_ff};
      mid_diff   = {1'b0, id} - {1'b0, mid_base_ff};
      large_diff = {1'b0, id} - {1'b0, large_base_ff};
      small_hit  = !req_tuser && !small_diff[ID_W]
                   && (small_diff[ID_W-1:0] < ID_W'(SMALL_COUNT));
      mid0_hit   = !req_tuser && !mid_diff[ID_W]
                   && (mid_diff[ID_W-1:0] < ID_W'(MID_PER_BUS));
      mid1_hit   = req_tuser && !mid_diff[ID_W]
                   && (mid_diff[ID_W-1:0] >= ID_W'(MID_PER_BUS))
                   && (mid_diff[ID_W-1:0] < ID_W'(2 * MID_PER_BUS));
      large_hit  = req_tuser && !large_diff[ID_W]
                   && (large_diff[ID_W-1:0] < ID_W'(LARGE_COUNT));
      hit        = small_hit || mid0_hit || mid1_hit || large_hit;
   end

   // classify and unpack the payload, small wins on bus 0, mid wins on bus 1
   always_comb begin
      item_in.enc     = {req_tdata[ID_W +: BYTE_W], req_tdata[ID_W + BYTE_W +: BYTE_W]};
      item_in.speed   = {req_tdata[ID_W + 2*BYTE_W +: BYTE_W],
                         req_tdata[ID_W + 3*BYTE_W +: BYTE_W]};
      item_in.current = {req_tdata[ID_W + 4*BYTE_W +: BYTE_W],
                         req_tdata[ID_W + 5*BYTE_W +: BYTE_W]};
      item_in.temp    = req_tdata[ID_W + 6*BYTE_W +: BYTE_W];
      if (small_hit) begin
         item_in.grp  = GRP_SMALL;
         item_in.sub  = small_diff[SUB_W-1:0];
         item_in.slot = SLOT_W'(small_diff[SUB_W-1:0]);
      end else if (mid0_hit || mid1_hit) begin
         item_in.grp  = GRP_MID;
         item_in.sub  = mid_diff[SUB_W-1:0];
         item_in.slot = MID_SLOT0 + SLOT_W'(mid_diff[SUB_W-1:0]);
      end else begin
         item_in.grp  = GRP_LARGE;
         item_in.sub  = large_diff[SUB_W-1:0];
         item_in.slot = LARGE_SLOT0 + SLOT_W'(large_diff[SUB_W-1:0]);
      end
   end

   // queue control, unmatched frames are accepted and dropped
   always_comb begin
      req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
      push       = req_tvalid && req_tready && hit;
      take       = pop && (count_ff != '0);
      count_in   = count_ff + QCNT_W'(push) - QCNT_W'(take);
      head.valid = (count_ff != '0);
      head.item  = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mfd_unwrap.sv -----
`default_nettype none

module mfd_unwrap import mfd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  head_type head,
   output logic     rec_valid,
   output rec_type  rec
);

   localparam int WIDE_W = TOTAL_W + 2;
   localparam logic signed [WIDE_W-1:0] TOTAL_HI = {3'b000, {(TOTAL_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] TOTAL_LO = {3'b111, {(TOTAL_W-1){1'b0}}};

   logic                      seen_ff [NUM_SLOTS];
   logic [ENC_W-1:0]          off_ff [NUM_SLOTS];
   logic [ENC_W-1:0]          last_ff [NUM_SLOTS];
   logic signed [TURN_W-1:0]  turns_ff [NUM_SLOTS];
   logic                      seen_rd;
   logic [ENC_W-1:0]          off_rd;
   logic [ENC_W-1:0]          last_rd;
   logic signed [TURN_W-1:0]  turns_rd;
   logic signed [TURN_W-1:0]  turns_in;
   logic signed [ENC_W:0]     delta;
   logic                      take;
   logic                      u_valid_ff;
   rec_type                   u_rec_ff;
   rec_type                   u_rec_in;
   logic [ENC_W-1:0]          u_off_ff;
   logic                      t_valid_ff;
   rec_type                   t_rec_ff;
   rec_type                   t_rec_in;
   logic signed [WIDE_W-1:0]  total_wide;

   // slot lookup, an unseen slot reads as its own first frame
   always_comb begin
      take     = adv && head.valid;
      seen_rd  = seen_ff[head.item.slot];
      off_rd   = seen_rd ? off_ff[head.item.slot] : head.item.enc;
      last_rd  = seen_rd ? last_ff[head.item.slot] : head.item.enc;
      turns_rd = seen_rd ? turns_ff[head.item.slot] : '0;
      delta    = $signed({1'b0, head.item.enc}) - $signed({1'b0, last_rd});
   end

   // turn counting on half-range jumps, saturating
   always_comb begin
      turns_in = turns_rd;
      if (delta > ENC_HALF) begin
         if (turns_rd != TURN_MIN) begin
            turns_in = turns_rd - 19'sd1;
         end
      end else if (delta < ENC_HALF_NEG) begin
         if (turns_rd != TURN_MAX) begin
            turns_in = turns_rd + 19'sd1;
         end
      end
      u_rec_in.grp     = head.item.grp;
      u_rec_in.sub     = head.item.sub;
      u_rec_in.first   = !seen_rd;
      u_rec_in.enc     = head.item.enc;
      u_rec_in.speed   = head.item.speed;
      u_rec_in.current = head.item.current;
      u_rec_in.temp    = head.item.temp;
      u_rec_in.turns   = turns_in;
      u_rec_in.total   = '0;
   end

   // slot seen flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            seen_ff[i] <= 1'b0;
         end
      end else if (take) begin
         seen_ff[head.item.slot] <= 1'b1;
      end
   end

   // slot state write-back
   always_ff @(posedge clock) begin
      if (take) begin
         off_ff[head.item.slot]   <= off_rd;
         last_ff[head.item.slot]  <= head.item.enc;
         turns_ff[head.item.slot] <= turns_in;
      end
   end

   // total position: turns * 8192 + encoder - offset, saturated to 32 bits
   always_comb begin
      total_wide = $signed({{(WIDE_W-TURN_W-ENC_SHIFT){u_rec_ff.turns[TURN_W-1]}},
                            u_rec_ff.turns, {ENC_SHIFT{1'b0}}})
                   + $signed({{(WIDE_W-ENC_W){1'b0}}, u_rec_ff.enc})
                   - $signed({{(WIDE_W-ENC_W){1'b0}}, u_off_ff});
      t_rec_in = u_rec_ff;
      if (total_wide > TOTAL_HI) begin
         t_rec_in.total = TOTAL_HI[TOTAL_W-1:0];
      end else if (total_wide < TOTAL_LO) begin
         t_rec_in.total = TOTAL_LO[TOTAL_W-1:0];
      end else begin
         t_rec_in.total = total_wide[TOTAL_W-1:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else if (adv) begin
         u_valid_ff <= head.valid;
         t_valid_ff <= u_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         u_rec_ff <= u_rec_in;
         u_off_ff <= off_rd;
         t_rec_ff <= t_rec_in;
      end
   end

   assign rec_valid = t_valid_ff;
   assign rec       = t_rec_ff;

endmodule

`default_nettype wire

// ----- rtl/mfd_scale.sv -----
`default_nettype none

module mfd_scale import mfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rec_type           in_rec,
   output logic              out_valid,
   output rec_type           out_rec,
   output logic [GEAR_W-1:0] out_geared
);

   localparam int PIPE    = 9;
   localparam int PROD_W  = TOTAL_W + RECIP_W;
   localparam int Y_W     = DIV_W + NUM_W;
   localparam int PROD2_W = Y_W + RECIP_W;
   localparam int DQ_W    = TOTAL_W + DIV_W;
   localparam int HI_W    = TOTAL_W + NUM_W;
   localparam int DQ2_W   = Y_W + DIV_W;

   rec_type              rec_ff [PIPE];
   logic                 valid_ff [PIPE];

   // stage 1: sign, magnitude and group constants
   logic                 s1_sign_in;
   logic [TOTAL_W-1:0]   s1_mag_in;
   logic [DIV_W-1:0]     s1_dv_in;
   logic [RECIP_W-1:0]   s1_rc_in;
   logic [NUM_W-1:0]     s1_nm_in;
   logic                 s1_sign_ff;
   logic [TOTAL_W-1:0]   s1_mag_ff;
   logic [DIV_W-1:0]     s1_dv_ff;
   logic [RECIP_W-1:0]   s1_rc_ff;
   logic [NUM_W-1:0]     s1_nm_ff;
   // stage 2: reciprocal product
   logic [PROD_W-1:0]    s2_prod_in;
   logic [PROD_W-1:0]    s2_prod_ff;
   logic                 s2_sign_ff;
   logic [TOTAL_W-1:0]   s2_mag_ff;
   logic [DIV_W-1:0]     s2_dv_ff;
   logic [RECIP_W-1:0]   s2_rc_ff;
   logic [NUM_W-1:0]     s2_nm_ff;
   // stage 3: quotient estimate and back-multiply
   logic [TOTAL_W-1:0]   s3_q_in;
   logic [DQ_W-1:0]      s3_dq_full;
   logic [TOTAL_W-1:0]   s3_q_ff;
   logic [TOTAL_W-1:0]   s3_dq_ff;
   logic                 s3_sign_ff;
   logic [TOTAL_W-1:0]   s3_mag_ff;
   logic [DIV_W-1:0]     s3_dv_ff;
   logic [RECIP_W-1:0]   s3_rc_ff;
   logic [NUM_W-1:0]     s3_nm_ff;
   // stage 4: quotient and remainder corrected
   logic [TOTAL_W-1:0]   s4_rem;
   logic [TOTAL_W-1:0]   s4_rfix;
   logic [TOTAL_W-1:0]   s4_q_in;
   logic [TOTAL_W-1:0]   s4_q_ff;
   logic [DIV_W-1:0]     s4_r_ff;
   logic                 s4_sign_ff;
   logic [DIV_W-1:0]     s4_dv_ff;
   logic [RECIP_W-1:0]   s4_rc_ff;
   logic [NUM_W-1:0]     s4_nm_ff;
   // stage 5: scale quotient and remainder by the numerator
   logic [HI_W-1:0]      s5_hi_full;
   logic [Y_W-1:0]       s5_y_in;
   logic [GEAR_W-1:0]    s5_hi_ff;
   logic [Y_W-1:0]       s5_y_ff;
   logic                 s5_sign_ff;
   logic [DIV_W-1:0]     s5_dv_ff;
   logic [RECIP_W-1:0]   s5_rc_ff;
   // stage 6: reciprocal product of the scaled remainder
   logic [PROD2_W-1:0]   s6_prod_in;
   logic [PROD2_W-1:0]   s6_prod_ff;
   logic [GEAR_W-1:0]    s6_hi_ff;
   logic [Y_W-1:0]       s6_y_ff;
   logic                 s6_sign_ff;
   logic [DIV_W-1:0]     s6_dv_ff;
   // stage 7: fraction estimate and back-multiply
   logic [Y_W-1:0]       s7_q_in;
   logic [DQ2_W-1:0]     s7_dq_full;
   logic [Y_W-1:0]       s7_q_ff;
   logic [Y_W-1:0]       s7_dq_ff;
   logic [GEAR_W-1:0]    s7_hi_ff;
   logic [Y_W-1:0]       s7_y_ff;
   logic                 s7_sign_ff;
   logic [DIV_W-1:0]     s7_dv_ff;
   // stage 8: corrected fraction added in
   logic [Y_W-1:0]       s8_rem;
   logic [Y_W-1:0]       s8_q;
   logic [GEAR_W-1:0]    s8_mag_in;
   logic [GEAR_W-1:0]    s8_mag_ff;
   logic                 s8_sign_ff;
   // stage 9: sign restored, output register
   logic [GEAR_W-1:0]    s9_geared_in;
   logic [GEAR_W-1:0]    s9_geared_ff;

   // stage 1
   always_comb begin
      s1_sign_in = in_rec.total[TOTAL_W-1];
      s1_mag_in  = s1_sign_in ? (TOTAL_W'(0) - in_rec.total) : in_rec.total;
      case (in_rec.grp)
         GRP_SMALL: begin
            s1_dv_in = DIV_SMALL;
            s1_rc_in = RECIP_SMALL;
            s1_nm_in = NUM_SMALL;
         end
         GRP_MID: begin
            s1_dv_in = DIV_MID;
            s1_rc_in = RECIP_MID;
            s1_nm_in = NUM_MID;
         end
         default: begin
            s1_dv_in = DIV_LARGE;
            s1_rc_in = RECIP_LARGE;
            s1_nm_in = NUM_LARGE;
         end
      endcase
   end

   // stages 2 to 4: magnitude / divisor, estimate is exact or one low
   always_comb begin
      s2_prod_in = PROD_W'(s1_mag_ff) * PROD_W'(s1_rc_ff);
      s3_q_in    = s2_prod_ff[PROD_W-1:RECIP_W];
      s3_dq_full = DQ_W'(s3_q_in) * DQ_W'(s2_dv_ff);
      s4_rem     = s3_mag_ff - s3_dq_ff;
      if (s4_rem >= TOTAL_W'(s3_dv_ff)) begin
         s4_q_in = s3_q_ff + 1'b1;
         s4_rfix = s4_rem - TOTAL_W'(s3_dv_ff);
      end else begin
         s4_q_in = s3_q_ff;
         s4_rfix = s4_rem;
      end
   end

   // stages 5 to 8: q * num + (r * num) / divisor
   always_comb begin
      s5_hi_full   = HI_W'(s4_q_ff) * HI_W'(s4_nm_ff);
      s5_y_in      = Y_W'(s4_r_ff) * Y_W'(s4_nm_ff);
      s6_prod_in   = PROD2_W'(s5_y_ff) * PROD2_W'(s5_rc_ff);
      s7_q_in      = s6_prod_ff[PROD2_W-1:RECIP_W];
      s7_dq_full   = DQ2_W'(s7_q_in) * DQ2_W'(s6_dv_ff);
      s8_rem       = s7_y_ff - s7_dq_ff;
      s8_q         = s7_q_ff + Y_W'(s8_rem >= Y_W'(s7_dv_ff));
      s8_mag_in    = s7_hi_ff + GEAR_W'(s8_q);
      s9_geared_in = s8_sign_ff ? (GEAR_W'(0) - s8_mag_ff) : s8_mag_ff;
   end

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < PIPE; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         rec_ff[0] <= in_rec;
         for (int i = 1; i < PIPE; i++) begin
            rec_ff[i] <= rec_ff[i-1];
         end
         s1_sign_ff   <= s1_sign_in;
         s1_mag_ff    <= s1_mag_in;
         s1_dv_ff     <= s1_dv_in;
         s1_rc_ff     <= s1_rc_in;
         s1_nm_ff     <= s1_nm_in;
         s2_prod_ff   <= s2_prod_in;
         s2_sign_ff   <= s1_sign_ff;
         s2_mag_ff    <= s1_mag_ff;
         s2_dv_ff     <= s1_dv_ff;
         s2_rc_ff     <= s1_rc_ff;
         s2_nm_ff     <= s1_nm_ff;
         s3_q_ff      <= s3_q_in;
         s3_dq_ff     <= s3_dq_full[TOTAL_W-1:0];
         s3_sign_ff   <= s2_sign_ff;
         s3_mag_ff    <= s2_mag_ff;
         s3_dv_ff     <= s2_dv_ff;
         s3_rc_ff     <= s2_rc_ff;
         s3_nm_ff     <= s2_nm_ff;
         s4_q_ff      <= s4_q_in;
         s4_r_ff      <= s4_rfix[DIV_W-1:0];
         s4_sign_ff   <= s3_sign_ff;
         s4_dv_ff     <= s3_dv_ff;
         s4_rc_ff     <= s3_rc_ff;
         s4_nm_ff     <= s3_nm_ff;
         s5_hi_ff     <= s5_hi_full[GEAR_W-1:0];
         s5_y_ff      <= s5_y_in;
         s5_sign_ff   <= s4_sign_ff;
         s5_dv_ff     <= s4_dv_ff;
         s5_rc_ff     <= s4_rc_ff;
         s6_prod_ff   <= s6_prod_in;
         s6_hi_ff     <= s5_hi_ff;
         s6_y_ff      <= s5_y_ff;
         s6_sign_ff   <= s5_sign_ff;
         s6_dv_ff     <= s5_dv_ff;
         s7_q_ff      <= s7_q_in;
         s7_dq_ff     <= s7_dq_full[Y_W-1:0];
         s7_hi_ff     <= s6_hi_ff;
         s7_y_ff      <= s6_y_ff;
         s7_sign_ff   <= s6_sign_ff;
         s7_dv_ff     <= s6_dv_ff;
         s8_mag_ff    <= s8_mag_in;
         s8_sign_ff   <= s7_sign_ff;
         s9_geared_ff <= s9_geared_in;
      end
   end

   assign out_valid  = valid_ff[PIPE-1];
   assign out_rec    = rec_ff[PIPE-1];
   assign out_geared = s9_geared_ff;

endmodule

`default_nettype wire

// ----- bench/mfd_feedback_checker.sv -----
`timescale 1ns / 1ps

// watches the frame, result and register ports, predicts the decoded feedback
// of every accepted frame and compares it with the result beats in order
module mfd_feedback_checker import mfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_addr,
   input  logic [ID_W-1:0]       csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // std_id, data_byte_0 .. data_byte_6, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // bus_select
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor_slot, first_frame, encoder_value, rotor_speed, drive_current, temperature,
   // turn_count, total_position, geared_position, zero pad
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   // motor_group
   input  logic [GRP_W-1:0]      rsp_tuser,
   output int                    pending,
   output int                    errors
);

   localparam int REPORT_LIMIT = 10;
   localparam longint TOTAL_HI = 64'sd2147483647;
   localparam longint TOTAL_LO = -64'sd2147483648;

   // bit offsets of the result fields in rsp_tdata
   localparam int OFS_FIRST = SUB_W;
   localparam int OFS_ENC   = OFS_FIRST + 1;
   localparam int OFS_SPEED = OFS_ENC + ENC_W;
   localparam int OFS_CUR   = OFS_SPEED + ENC_W;
   localparam int OFS_TEMP  = OFS_CUR + ENC_W;
   localparam int OFS_TURNS = OFS_TEMP + BYTE_W;
   localparam int OFS_TOTAL = OFS_TURNS + TURN_W;
   localparam int OFS_GEAR  = OFS_TOTAL + TOTAL_W;

   typedef struct packed {
      group_type          grp;
      logic [SUB_W-1:0]   sub;
      logic               first;
      logic [ENC_W-1:0]   enc;
      logic [ENC_W-1:0]   speed;
      logic [ENC_W-1:0]   current;
      logic [BYTE_W-1:0]  temp;
      logic [TURN_W-1:0]  turns;
      logic [TOTAL_W-1:0] total;
      logic [GEAR_W-1:0]  geared;
   } feedback_type;

   feedback_type expected_fb[$];

   // base ids as last written
   int small_base;
   int mid_base;
   int large_base;

   // per-slot unwrap state
   logic             seen [NUM_SLOTS];
   logic [ENC_W-1:0] offset [NUM_SLOTS];
   logic [ENC_W-1:0] prev_enc [NUM_SLOTS];
   int               turn_cnt [NUM_SLOTS];

   int fail_count = 0;

   function automatic logic [BYTE_W-1:0] frame_byte(input logic [REQ_DATA_W-1:0] beat,
                                                    input int n);
      return beat[ID_W + BYTE_W * n +: BYTE_W];
   endfunction

   function automatic void show_feedback(input string tag, input feedback_type fb);
      $display("%s group %0d slot %0d first %0d enc %h speed %h current %h temp %h",
               tag, fb.grp, fb.sub, fb.first, fb.enc, fb.speed, fb.current, fb.temp);
      $display("%s turns %h total %h geared %h", tag, fb.turns, fb.total, fb.geared);
   endfunction

   // classify one frame, update the slot and queue its feedback
   task automatic decode_frame(input logic bus, input logic [REQ_DATA_W-1:0] beat);
      int id;
      int k;
      int slot;
      int enc_i;
      int prev_i;
      int jump;
      logic hit;
      logic [ENC_W-1:0] enc;
      longint total;
      longint geared;
      feedback_type want;
      id = int'(beat[ID_W-1:0]);
      hit = 1'b1;
      k = 0;
      want.grp = GRP_SMALL;
      if (!bus) begin
         if (id >= small_base && id - small_base < SMALL_COUNT) begin
            want.grp = GRP_SMALL;
            k = id - small_base;
         end else if (id >= mid_base && id - mid_base < MID_PER_BUS) begin
            want.grp = GRP_MID;
            k = id - mid_base;
         end else begin
            hit = 1'b0;
         end
      end else begin
         // mid motors 2..3 sit on bus 1 and win over the large group
         if (id >= mid_base + MID_PER_BUS && id - mid_base < 2 * MID_PER_BUS) begin
            want.grp = GRP_MID;
            k = id - mid_base;
         end else if (id >= large_base && id - large_base < LARGE_COUNT) begin
            want.grp = GRP_LARGE;
            k = id - large_base;
         end else begin
            hit = 1'b0;
         end
      end
      if (!hit)
         return;

      case (want.grp)
         GRP_SMALL: slot = k;
         GRP_MID:   slot = int'(MID_SLOT0) + k;
         default:   slot = int'(LARGE_SLOT0) + k;
      endcase

      enc = {frame_byte(beat, 0), frame_byte(beat, 1)};
      // first frame latches the zero offset, so the jump is zero
      want.first = !seen[slot];
      if (!seen[slot]) begin
         seen[slot] = 1'b1;
         offset[slot] = enc;
         prev_enc[slot] = enc;
      end

      // unwrap on jumps beyond half a turn, saturating turn count
      enc_i = int'(enc);
      prev_i = int'(prev_enc[slot]);
      jump = enc_i - prev_i;
      if (jump > ENC_HALF) begin
         if (turn_cnt[slot] > TURN_MIN)
            turn_cnt[slot]--;
      end else if (jump < ENC_HALF_NEG) begin
         if (turn_cnt[slot] < TURN_MAX)
            turn_cnt[slot]++;
      end
      prev_enc[slot] = enc;

      prev_i = int'(offset[slot]);
      total = longint'(turn_cnt[slot]);
      total = total * (1 << ENC_SHIFT) + enc_i - prev_i;
      if (total > TOTAL_HI)
         total = TOTAL_HI;
      if (total < TOTAL_LO)
         total = TOTAL_LO;

      // signed 64-bit total keeps the divide signed, truncating toward zero
      case (want.grp)
         GRP_SMALL: geared = (total * 256) / 36;
         GRP_MID:   geared = (total * 256 * 187) / 3591;
         default:   geared = total * 256;
      endcase

      want.sub = k[SUB_W-1:0];
      want.enc = enc;
      want.speed = {frame_byte(beat, 2), frame_byte(beat, 3)};
      want.current = {frame_byte(beat, 4), frame_byte(beat, 5)};
      want.temp = frame_byte(beat, 6);
      want.turns = turn_cnt[slot][TURN_W-1:0];
      want.total = total[TOTAL_W-1:0];
      want.geared = geared[GEAR_W-1:0];
      expected_fb.push_back(want);
   endtask

   // compare one result beat with the oldest prediction
   task automatic check_result();
      feedback_type got;
      feedback_type want;
      got.grp = group_type'(rsp_tuser);
      got.sub = rsp_tdata[SUB_W-1:0];
      got.first = rsp_tdata[OFS_FIRST];
      got.enc = rsp_tdata[OFS_ENC +: ENC_W];
      got.speed = rsp_tdata[OFS_SPEED +: ENC_W];
      got.current = rsp_tdata[OFS_CUR +: ENC_W];
      got.temp = rsp_tdata[OFS_TEMP +: BYTE_W];
      got.turns = rsp_tdata[OFS_TURNS +: TURN_W];
      got.total = rsp_tdata[OFS_TOTAL +: TOTAL_W];
      got.geared = rsp_tdata[OFS_GEAR +: GEAR_W];
      if (expected_fb.size() == 0) begin
         if (fail_count < REPORT_LIMIT) begin
            $display("result beat with nothing expected at %0t", $realtime);
            show_feedback("  actual  ", got);
         end
         fail_count++;
      end else begin
         want = expected_fb.pop_front();
         if (got !== want) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("feedback mismatch at %0t", $realtime);
               show_feedback("  expected", want);
               show_feedback("  actual  ", got);
            end
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         small_base = int'(SMALL_BASE_RST);
         mid_base = int'(MID_BASE_RST);
         large_base = int'(LARGE_BASE_RST);
         for (int s = 0; s < NUM_SLOTS; s++) begin
            seen[s] = 1'b0;
            offset[s] = '0;
            prev_enc[s] = '0;
            turn_cnt[s] = 0;
         end
         expected_fb.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               REG_SMALL_BASE: small_base = int'(csr_wdata);
               REG_MID_BASE:   mid_base = int'(csr_wdata);
               REG_LARGE_BASE: large_base = int'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            decode_frame(req_tuser, req_tdata);
      end
      pending <= expected_fb.size();
      errors <= fail_count;
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import mfd_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_FRAMES  = 190;
   localparam int SPIN_LAPS     = 4;
   localparam int LAP_FRAMES    = 16;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [REG_IDX_W-1:0]  csr_addr;
   logic [ID_W-1:0]       csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [GRP_W-1:0]      rsp_tuser;
   int                    pending;
   int                    errors;

   // stretches with no idling on either side
   bit quiet;
   int unsigned cycle_count = 0;

   // base ids as written, used to aim frames at slots
   int small_base;
   int mid_base;
   int large_base;
   logic [ENC_W-1:0] trail [NUM_SLOTS];

   motor_feedback_multiturn_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mfd_feedback_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .pending    (pending),
      .errors     (errors)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_wait();
      if (quiet || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 15);
   endfunction

   // encoder walk: mostly small moves wrapping at one turn, some jumps at the
   // half-turn threshold, some arbitrary 16-bit readings, some all-ones or all-zeros readings
   function automatic logic [ENC_W-1:0] next_encoder(input logic [ENC_W-1:0] prev);
      int p;
      int step;
      int r;
      p = prev;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         step = $urandom_range(0, 8192);
         step = step - 4096;
         return ENC_W'((p + step) & 8191);
      end else if (r < 8) begin
         case ($urandom_range(0, 3))
            0: step = 4096;
            1: step = 4097;
            2: step = -4096;
            default: step = -4097;
         endcase
         return ENC_W'(p + step);
      end else if (r == 8) begin
         return ENC_W'($urandom_range(0, 65535));
      end
      return $urandom_range(0, 1) ? {ENC_W{1'b1}} : {ENC_W{1'b0}};
   endfunction

   // one frame beat, after a random gap
   task automatic send_frame(input logic bus, input logic [ID_W-1:0] id,
                             input logic [ENC_W-1:0] enc, input logic [ENC_W-1:0] spd,
                             input logic [ENC_W-1:0] cur, input logic [BYTE_W-1:0] temp);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= bus;
      req_tdata <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, temp, cur[7:0], cur[15:8],
                    spd[7:0], spd[15:8], enc[7:0], enc[15:8], id};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and let every result and any dropped frame drain
   task automatic wait_idle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[ID_W-1:0];
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic set_bases(input int s, input int m, input int l);
      wait_idle();
      write_reg(REG_SMALL_BASE, s);
      write_reg(REG_MID_BASE, m);
      write_reg(REG_LARGE_BASE, l);
      small_base = s;
      mid_base = m;
      large_base = l;
   endtask

   // laps of a saw pattern that moves the turn count by 14 per lap
   task automatic spin_turns(input logic bus, input int id, input logic [ENC_W-1:0] seed_enc,
                             input int start, input int step);
      send_frame(bus, id[ID_W-1:0], seed_enc, ENC_W'($urandom), ENC_W'($urandom),
                 BYTE_W'($urandom));
      repeat (SPIN_LAPS) begin
         for (int i = 0; i < LAP_FRAMES; i++)
            send_frame(bus, id[ID_W-1:0], ENC_W'(start + step * i),
                       ENC_W'($urandom), ENC_W'($urandom), BYTE_W'($urandom));
      end
   endtask

   // mostly frames aimed at slots with coherent encoder walks, the rest noise ids
   task automatic run_random();
      int slot;
      int id;
      logic bus;
      logic [ENC_W-1:0] enc;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
         quiet = (n % 100) >= 80;
         if (n == PHASE_FRAMES / 2)
            wait_idle();
         slot = $urandom_range(0, NUM_SLOTS - 1);
         if (slot < SMALL_COUNT) begin
            bus = 1'b0;
            id = small_base + slot;
         end else if (slot < SMALL_COUNT + MID_PER_BUS) begin
            bus = 1'b0;
            id = mid_base + slot - SMALL_COUNT;
         end else if (slot < int'(LARGE_SLOT0)) begin
            bus = 1'b1;
            id = mid_base + slot - SMALL_COUNT;
         end else begin
            bus = 1'b1;
            id = large_base + slot - int'(LARGE_SLOT0);
         end
         enc = next_encoder(trail[slot]);
         if ($urandom_range(0, 9) < 8) begin
            trail[slot] = enc;
         end else begin
            // noise: arbitrary id or one just around a group
            bus = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
               id = $urandom_range(0, 2047);
            else
               id = id + $urandom_range(0, 6) - 3;
            enc = ENC_W'($urandom_range(0, 65535));
         end
         send_frame(bus, id[ID_W-1:0], enc, ENC_W'($urandom), ENC_W'($urandom),
                    BYTE_W'($urandom));
      end
      quiet = 1'b0;
   endtask

   // result side: random stalls between beats
   initial begin
      int stall;
      rsp_tready = 1'b1;
      forever begin
         stall = pick_wait();
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock) rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // stimulus and verdict
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = REG_SMALL_BASE;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      quiet = 1'b0;
      small_base = int'(SMALL_BASE_RST);
      mid_base = int'(MID_BASE_RST);
      large_base = int'(LARGE_BASE_RST);
      for (int s = 0; s < NUM_SLOTS; s++)
         trail[s] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // run small motor 3 up and large motor 2 down by several whole turns
      quiet = 1'b1;
      spin_turns(1'b0, small_base + 3, 16'h0000, 65535, -4097);
      spin_turns(1'b1, large_base + 2, 16'hFFFF, 0, 4097);
      quiet = 1'b0;

      // first frames with field extremes and the unwrap thresholds
      send_frame(1'b0, 11'd513, 16'h0000, 16'h8000, 16'h7FFF, 8'h00);
      send_frame(1'b0, 11'd513, 16'h1000, 16'h0000, 16'h0000, 8'h01);
      send_frame(1'b0, 11'd513, 16'h2001, 16'h1234, 16'hFFFF, 8'h02);
      send_frame(1'b0, 11'd513, 16'h1000, 16'hFFFF, 16'h0001, 8'h03);
      send_frame(1'b0, 11'd513, 16'h0000, 16'h7FFF, 16'h8000, 8'h04);
      send_frame(1'b0, 11'd514, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
      send_frame(1'b0, 11'd514, 16'h0000, 16'h8000, 16'h7FFF, 8'h80);
      // small negative totals check rounding toward zero in each group
      send_frame(1'b0, 11'd515, 16'h1234, 16'h0001, 16'hFFFF, 8'h80);
      send_frame(1'b0, 11'd515, 16'h1233, 16'h5555, 16'hAAAA, 8'h55);
      send_frame(1'b0, 11'd517, 16'h0100, 16'hAAAA, 16'h5555, 8'hAA);
      send_frame(1'b0, 11'd517, 16'h00FF, 16'h0000, 16'h0000, 8'h00);
      send_frame(1'b0, 11'd518, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_frame(1'b1, 11'd519, 16'h8000, 16'h0F0F, 16'hF0F0, 8'h0F);
      send_frame(1'b1, 11'd520, 16'h0000, 16'hF0F0, 16'h0F0F, 8'hF0);
      send_frame(1'b1, 11'd521, 16'h0005, 16'h0000, 16'h0000, 8'h10);
      send_frame(1'b1, 11'd521, 16'h0004, 16'h0000, 16'h0000, 8'h11);
      send_frame(1'b1, 11'd522, 16'hABCD, 16'h1111, 16'h2222, 8'h33);
      // ids that belong to no slot on their bus
      send_frame(1'b0, 11'd519, 16'h1111, 16'h0000, 16'h0000, 8'h00);
      send_frame(1'b1, 11'd513, 16'h2222, 16'h0000, 16'h0000, 8'h00);
      send_frame(1'b1, 11'd524, 16'h3333, 16'h0000, 16'h0000, 8'h00);
      send_frame(1'b0, 11'd0, 16'h4444, 16'h0000, 16'h0000, 8'h00);
      send_frame(1'b1, 11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      // the spun slots once more
      send_frame(1'b0, 11'd516, 16'hFFFF, 16'h0000, 16'h0000, 8'h00);
      send_frame(1'b1, 11'd523, 16'h0000, 16'h0000, 16'h0000, 8'h00);

      run_random();
      // bases at the ends of the id range, some slots past 2047
      set_bases(0, 2047, 2045);
      run_random();
      // overlapping groups on both buses
      set_bases(100, 102, 104);
      run_random();
      set_bases(2047, 0, 0);
      run_random();
      repeat (2) begin
         set_bases($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047));
         run_random();
      end

      wait_idle();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
